### src/battery_rate_estimator_macros.svh
// assertion macros used by the rate estimator
`ifndef BATTERY_RATE_ESTIMATOR_MACROS_SVH
`define BATTERY_RATE_ESTIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BRE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BRE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define BRE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define BRE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### src/bre_pkg.sv
package bre_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 7;
  localparam int CHG_W   = 8;
  localparam int WIN_W   = 22;
  localparam int MDEL_W  = 7;
  localparam int MSMP_W  = 10;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = 39;
  localparam int DIVD_W  = 56;
  localparam int DIVS_W  = 32;
  localparam int DCNT_W  = 6;

  localparam logic [TIME_W-1:0]  MS_PER_HOUR = 32'd3600000;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 7'd100;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW      = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_DELTA   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_SAMPLES = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RESET      = 22'd300000;
  localparam logic [MDEL_W-1:0] MIN_DELTA_RESET   = 7'd3;
  localparam logic [MSMP_W-1:0] MIN_SAMPLES_RESET = 10'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EST,
    ST_MUL_RATE,
    ST_DIV_RATE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_TIME,
    ST_EMIT
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### src/bre_ram.sv
module bre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bre_div.sv
module bre_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bre_pkg::DIVD_W-1:0]  dividend,
  input  logic [bre_pkg::DIVS_W-1:0]  divisor,
  output logic [bre_pkg::DIVD_W-1:0]  quotient,
  output bre_pkg::div_status_t        status
);
  import bre_pkg::*;

  logic [DIVS_W:0]   rem;
  logic [DIVS_W-1:0] dsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              fits;

  // one restoring step per cycle
  assign rem_sh  = {rem[DIVS_W-1:0], quotient[DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
        cnt      <= DCNT_W'(DIVD_W - 1);
      end else if (busy) begin
        rem      <= fits ? rem_sub : rem_sh;
        quotient <= {quotient[DIVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### src/battery_rate_estimator.sv
// Battery rate estimator.
// Input stream s_*: tdata carries one sample {chg_code, pct, now_ms}. Each
// accepted transaction gives exactly one result on m_*: tuser is the
// estimate valid flag, tdata holds rate, runtime and charge in Q16.16.
// Configuration port cfg_*: cfg_index selects window_ms (0), min_delta (1)
// or min_samples (2); other indexes are ignored. cfg_ready is always high.
// The work for one sample depends on its path: the read loop of the history
// memory (states ST_WALK_RD and ST_WALK_CHK) drops old samples that have left
// the window; the block stops there when too few samples are kept, and at ST_EST
// when the span or the change is too small; a zero change takes one 56-step pass
// of the shared divider and a full estimate takes two.
// s_tready is low while a sample is in work; the next sample is taken as
// soon as the result sits in the output register, even if it is stalled.
// A stalled receiver holds the output register and the block waits before
// writing the next result.
// Reset clears the ring, charge state, estimate and output; the history
// memory is not cleared and needs no clearing pass.
`include "battery_rate_estimator_macros.svh"
module battery_rate_estimator #(
  parameter int HISTORY_DEPTH = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [47:0]               s_tdata,   // now_ms, pct, chg_code, pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [95:0]               m_tdata,   // rate_q16, runtime_q16, charge_q16
  output logic                      m_tuser,   // est_ok
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bre_pkg::IDX_W-1:0] cfg_index,
  input  logic [bre_pkg::WIN_W-1:0] cfg_data
);
  import bre_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  state_t state, state_next;

  logic [WIN_W-1:0]   window_ms;
  logic [MDEL_W-1:0]  min_delta;
  logic [MSMP_W-1:0]  min_samples;

  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CHG_W-1:0]   last_chg;
  logic [TIME_W-1:0]  now_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic               est_valid;
  logic [31:0]        est_rate;
  logic [31:0]        est_runtime;
  logic [31:0]        est_charge;
  logic [DIVD_W-1:0]  num_r;

  // input fields
  logic [TIME_W-1:0]  in_now;
  logic [LEVEL_W-1:0] in_pct;
  logic [CHG_W-1:0]   in_chg;
  logic [LEVEL_W-1:0] in_lvl;
  logic               accept;
  logic               chg_diff;
  logic [AW-1:0]      head_base;
  logic [CW-1:0]      count_base;

  assign in_now   = s_tdata[31:0];
  assign in_pct   = s_tdata[38:32];
  assign in_chg   = s_tdata[46:39];
  assign in_lvl   = (in_pct > FULL_LEVEL) ? FULL_LEVEL : in_pct;
  assign accept   = s_tvalid && s_tready;
  assign chg_diff = in_chg != last_chg;
  assign head_base  = chg_diff ? '0 : head;
  assign count_base = chg_diff ? '0 : count;

  // history memory
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [TIME_W+LEVEL_W-1:0]   ram_rdata;
  logic [CW:0]                 old_sum;

  assign old_sum   = (CW+1)'(head) + (CW+1)'(HISTORY_DEPTH) - (CW+1)'(count);
  assign ram_raddr = (old_sum >= (CW+1)'(HISTORY_DEPTH)) ?
                     AW'(old_sum - (CW+1)'(HISTORY_DEPTH)) : AW'(old_sum);

  bre_ram #(
    .WIDTH(TIME_W + LEVEL_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (head_base),
    .wdata ({in_lvl, in_now}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // oldest sample against newest
  logic [TIME_W-1:0]  span;
  logic [LEVEL_W-1:0] lv_old;
  logic               falling;
  logic [LEVEL_W-1:0] mag;
  logic               expired;

  assign lv_old  = ram_rdata[TIME_W+LEVEL_W-1:TIME_W];
  assign span    = now_r - ram_rdata[TIME_W-1:0];
  assign falling = lvl_r < lv_old;
  assign mag     = falling ? (lv_old - lvl_r) : (lvl_r - lv_old);
  assign expired = span > TIME_W'(window_ms);

  // shared multiplier
  logic [LEVEL_W-1:0] mul_a;
  logic [TIME_W-1:0]  mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    if (state == ST_MUL_NUM) begin
      mul_a = falling ? lvl_r : (FULL_LEVEL - lvl_r);
      mul_b = span;
    end else begin
      mul_a = mag;
      mul_b = MS_PER_HOUR;
    end
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // shared divider
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic [DIVD_W-1:0] quo;
  div_status_t       div_st;

  assign div_dividend = (state == ST_MUL_RATE) ? DIVD_W'({prod, 16'd0}) : num_r;
  assign div_divisor  = (state == ST_MUL_RATE) ? span : DIVS_W'(prod);

  bre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .status   (div_st)
  );

  // saturation of quotients
  logic [31:0] rate_sat;
  logic [31:0] time_sat;

  always_comb begin
    if (falling) begin
      rate_sat = (quo >= DIVD_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
    end else begin
      rate_sat = (quo > DIVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end
    time_sat = (quo[DIVD_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // sequencer: next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        ram_re     = 1'b1;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (count > CW'(1) && expired) begin
          state_next = ST_WALK_RD;
        end else if (32'(count) < 32'(min_samples)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_EST;
        end
      end
      ST_EST: begin
        if (span == '0 || mag < min_delta) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL_RATE;
        end
      end
      ST_MUL_RATE: begin
        div_start  = 1'b1;
        state_next = ST_DIV_RATE;
      end
      ST_DIV_RATE: begin
        if (div_st.done) begin
          state_next = (mag == '0) ? ST_EMIT : ST_MUL_NUM;
        end
      end
      ST_MUL_NUM: begin
        state_next = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        div_start  = 1'b1;
        state_next = ST_DIV_TIME;
      end
      ST_DIV_TIME: begin
        if (div_st.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= WINDOW_RESET;
      min_delta   <= MIN_DELTA_RESET;
      min_samples <= MIN_SAMPLES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW:      window_ms   <= cfg_data;
        REG_MIN_DELTA:   min_delta   <= cfg_data[MDEL_W-1:0];
        REG_MIN_SAMPLES: min_samples <= cfg_data[MSMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ring control and estimate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      last_chg    <= '0;
      est_valid   <= 1'b0;
      est_rate    <= '0;
      est_runtime <= '0;
      est_charge  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            now_r    <= in_now;
            lvl_r    <= in_lvl;
            last_chg <= in_chg;
            head     <= (head_base == AW'(HISTORY_DEPTH - 1)) ? '0 : head_base + 1'b1;
            count    <= (count_base == CW'(HISTORY_DEPTH)) ? count_base : count_base + 1'b1;
            if (chg_diff) begin
              est_valid   <= 1'b0;
              est_rate    <= '0;
              est_runtime <= '0;
              est_charge  <= '0;
            end
          end
        end
        ST_WALK_CHK: begin
          if (count > CW'(1) && expired) begin
            count <= count - 1'b1;
          end else if (32'(count) < 32'(min_samples)) begin
            est_valid <= 1'b0;
          end
        end
        ST_EST: begin
          if (span == '0 || mag < min_delta) begin
            est_valid <= 1'b0;
          end else begin
            est_valid   <= 1'b1;
            est_runtime <= '0;
            est_charge  <= '0;
          end
        end
        ST_DIV_RATE: begin
          if (div_st.done) begin
            est_rate <= rate_sat;
          end
        end
        ST_MUL_NUM: begin
          num_r <= DIVD_W'({prod, 16'd0});
        end
        ST_DIV_TIME: begin
          if (div_st.done) begin
            if (falling) begin
              est_runtime <= time_sat;
            end else begin
              est_charge <= time_sat;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
      m_tuser  <= est_valid;
      m_tdata  <= {est_charge, est_runtime, est_rate};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `BRE_ASSERT_IMP(a_count_range, clk, rst, 1'b1, (count <= CW'(HISTORY_DEPTH)), "ring count above depth")
  `BRE_ASSERT_NXT(a_accept_walk, clk, rst, accept, (state == ST_WALK_RD && count != '0), "accepted sample not in ring")
  `BRE_ASSERT_NXT(a_count_hold, clk, rst, (state != ST_IDLE && state != ST_WALK_CHK), $stable(count), "ring count moved outside walk")
  `BRE_ASSERT_IMP(a_div_wait, clk, rst, (state == ST_DIV_RATE || state == ST_DIV_TIME), (div_st.busy || div_st.done), "waiting on idle divider")

endmodule
